>>> hdl/sus_pkg.sv
// Shared types and constants for the sorted unique set engine.
// No dependencies; every other file in hdl uses this package.
package sus_pkg;

	localparam int CAPACITY_DEFAULT = 64;

	localparam int MODE_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 6;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT   = 2'd0,
		MODE_REMOVE   = 2'd1,
		MODE_CONTAINS = 2'd2,
		MODE_READ     = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_DUPLICATE = 2'd1,
		STATUS_FULL      = 2'd2,
		STATUS_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY
	} state_t;

	typedef struct packed {
		logic load;
		logic cmp;
		logic commit;
	} cmd_t;

endpackage

>>> hdl/sus_item_if.sv
// Input channel of the sorted unique set engine: valid/ready plus one item.
// Depends on sus_pkg for field widths.
interface sus_item_if;
	logic                                 valid;
	logic                                 ready;
	logic [sus_pkg::MODE_W-1:0]           mode;
	logic signed [sus_pkg::VALUE_W-1:0]   value;
	logic [sus_pkg::INDEX_W-1:0]          index;

	modport source (output valid, output mode, output value, output index, input ready);
	modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

>>> hdl/sus_result_if.sv
// Output channel of the sorted unique set engine: valid/ready plus one result.
// Depends on sus_pkg for field widths.
interface sus_result_if;
	logic                                 valid;
	logic                                 ready;
	logic [sus_pkg::COUNT_W-1:0]          count;
	logic                                 found;
	logic signed [sus_pkg::VALUE_W-1:0]   read_value;
	logic [sus_pkg::STATUS_W-1:0]         status;

	modport source (output valid, output count, output found, output read_value,
		output status, input ready);
	modport sink   (input valid, input count, input found, input read_value,
		input status, output ready);
endinterface

>>> hdl/sus_ctrl.sv
// Controller of the sorted unique set engine: sequences load, compare, commit.
// Depends on sus_pkg for the state and command types.
module sus_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output sus_pkg::cmd_t cmd
);

	sus_pkg::state_t state_q;
	sus_pkg::state_t state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sus_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.cmp    = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			sus_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sus_pkg::S_CMP;
				end
			end
			sus_pkg::S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = sus_pkg::S_APPLY;
			end
			sus_pkg::S_APPLY: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					in_ready   = 1'b1;
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = sus_pkg::S_CMP;
					end else begin
						state_d = sus_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = sus_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> hdl/sus_datapath.sv
// Datapath of the sorted unique set engine: a row of entry cells with
// parallel compare, one-step shift on insert and remove, and the result register.
// Depends on sus_pkg for widths, codes and the command struct.
module sus_datapath #(
	parameter int CAPACITY = sus_pkg::CAPACITY_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sus_pkg::cmd_t                        cmd,
	input  logic [sus_pkg::MODE_W-1:0]           mode,
	input  logic signed [sus_pkg::VALUE_W-1:0]   value,
	input  logic [sus_pkg::INDEX_W-1:0]          index,
	output logic [sus_pkg::COUNT_W-1:0]          count,
	output logic                                 found,
	output logic signed [sus_pkg::VALUE_W-1:0]   read_value,
	output logic [sus_pkg::STATUS_W-1:0]         status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int XW    = (CNT_W > sus_pkg::INDEX_W) ? CNT_W : sus_pkg::INDEX_W;

	logic signed [sus_pkg::VALUE_W-1:0] entries_q [CAPACITY];
	logic signed [sus_pkg::VALUE_W-1:0] entries_d [CAPACITY];
	logic [CNT_W-1:0]                   count_q;
	logic [CNT_W-1:0]                   count_d;

	sus_pkg::mode_t                     mode_q;
	logic signed [sus_pkg::VALUE_W-1:0] value_q;
	logic [sus_pkg::INDEX_W-1:0]        index_q;

	logic [CAPACITY-1:0] lt_s1;
	logic [CAPACITY-1:0] eq_s1;
	logic [CAPACITY-1:0] ge_s1;
	logic [CAPACITY-1:0] sel_s1;

	logic [sus_pkg::COUNT_W-1:0]        count_o_q;
	logic                               found_o_q;
	logic signed [sus_pkg::VALUE_W-1:0] read_o_q;
	sus_pkg::status_t                   status_o_q;

	logic [XW-1:0]                      idx_x;
	logic                               dup;
	logic                               full;
	logic                               bad;
	logic                               do_ins;
	logic                               do_rm;
	logic signed [sus_pkg::VALUE_W-1:0] rd_sel;
	logic signed [sus_pkg::VALUE_W-1:0] rd_d;
	logic                               found_d;
	sus_pkg::status_t                   status_d;

	assign idx_x = XW'(index_q);

	// latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= sus_pkg::mode_t'(mode);
			value_q <= value;
			index_q <= index;
		end
	end

	// compare every cell against the item
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			for (int i = 0; i < CAPACITY; i++) begin
				lt_s1[i]  <= (XW'(i) < XW'(count_q)) && (entries_q[i] < value_q);
				eq_s1[i]  <= (XW'(i) < XW'(count_q)) && (entries_q[i] == value_q);
				ge_s1[i]  <= XW'(i) >= idx_x;
				sel_s1[i] <= XW'(i) == idx_x;
			end
		end
	end

	assign dup  = |eq_s1;
	assign full = count_q == CNT_W'(CAPACITY);
	assign bad  = idx_x >= XW'(count_q);

	always_comb begin
		rd_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_sel = rd_sel | (sel_s1[i] ? entries_q[i] : '0);
		end
	end

	always_comb begin
		do_ins   = 1'b0;
		do_rm    = 1'b0;
		found_d  = 1'b0;
		rd_d     = '0;
		status_d = sus_pkg::STATUS_OK;
		count_d  = count_q;
		case (mode_q)
			sus_pkg::MODE_INSERT: begin
				if (dup) begin
					status_d = sus_pkg::STATUS_DUPLICATE;
				end else if (full) begin
					status_d = sus_pkg::STATUS_FULL;
				end else begin
					do_ins  = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			sus_pkg::MODE_REMOVE: begin
				if (bad) begin
					status_d = sus_pkg::STATUS_BAD_INDEX;
				end else begin
					do_rm   = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			sus_pkg::MODE_CONTAINS: begin
				found_d = dup;
			end
			sus_pkg::MODE_READ: begin
				if (bad) begin
					rd_d     = sus_pkg::MOST_NEG;
					status_d = sus_pkg::STATUS_BAD_INDEX;
				end else begin
					rd_d = rd_sel;
				end
			end
			default: begin
				status_d = sus_pkg::STATUS_OK;
			end
		endcase
	end

	// next cell contents: open a gap at the insert point or close the removed slot
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			entries_d[i] = entries_q[i];
		end
		if (do_ins) begin
			if (!lt_s1[0]) begin
				entries_d[0] = value_q;
			end
			for (int i = 1; i < CAPACITY; i++) begin
				if (!lt_s1[i]) begin
					entries_d[i] = lt_s1[i-1] ? value_q : entries_q[i-1];
				end
			end
		end else if (do_rm) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (ge_s1[i]) begin
					entries_d[i] = entries_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && (do_ins || do_rm)) begin
			for (int i = 0; i < CAPACITY; i++) begin
				entries_q[i] <= entries_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			count_o_q  <= sus_pkg::COUNT_W'(count_d);
			found_o_q  <= found_d;
			read_o_q   <= rd_d;
			status_o_q <= status_d;
		end
	end

	assign count      = count_o_q;
	assign found      = found_o_q;
	assign read_value = read_o_q;
	assign status     = status_o_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && do_ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the count by one");

	a_query_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (mode_q == sus_pkg::MODE_CONTAINS || mode_q == sus_pkg::MODE_READ)
		|=> $stable(count_q))
		else $error("query changed the count");

	a_lt_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && CAPACITY > 1 |-> !(lt_s1[1] && !lt_s1[0]))
		else $error("compare vector not ordered at the head");
`endif

endmodule

>>> hdl/sorted_unique_set_engine.sv
// Sorted unique set engine: up to CAPACITY distinct signed values, ascending.
// An item beat passes the compare register, then shift and commit, before its result is valid.
// A new item beat is taken while idle or in the same cycle as the previous item commits.
// A waiting result lets one more item beat in; that item holds in commit and the input stalls.
// Reset (arst_n, asynchronous): set empty, no result pending; cell contents are not cleared.
module sorted_unique_set_engine #(
	parameter int CAPACITY = sus_pkg::CAPACITY_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	sus_item_if.sink      item,
	sus_result_if.source  result
);

	sus_pkg::cmd_t cmd;

	sus_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	sus_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (item.mode),
		.value      (item.value),
		.index      (item.index),
		.count      (result.count),
		.found      (result.found),
		.read_value (result.read_value),
		.status     (result.status)
	);

endmodule

>>> dv/sorted_unique_set_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted unique set engine: watches both channels, keeps its own copy
// of the set, predicts each result and compares it beat by beat.
// Depends on sus_pkg, sus_item_if and sus_result_if.
module sorted_unique_set_checker
	import sus_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEFAULT
) (
	input  logic  clk,
	input  logic  arst_n,
	sus_item_if   item,
	sus_result_if result,
	output int    mismatches,
	output int    pending,
	output int    set_size,
	output int    peak_size,
	output int    full_rejects,
	output int    bad_indexes
);

	typedef struct packed {
		logic [COUNT_W-1:0]        count;
		logic                      found;
		logic signed [VALUE_W-1:0] read_value;
		status_t                   status;
	} set_result_t;

	logic signed [VALUE_W-1:0] set_vals [CAPACITY];
	set_result_t               expected_results [$];
	set_result_t               want;
	set_result_t               got;

	assign pending = expected_results.size();

	task automatic apply_set_op(input mode_t op, input logic signed [VALUE_W-1:0] v,
		input logic [INDEX_W-1:0] idx, output set_result_t res);
		int pos;
		int i;
		res = '{count: '0, found: 1'b0, read_value: '0, status: STATUS_OK};
		pos = 0;
		while (pos < set_size && set_vals[pos] < v)
			pos++;
		case (op)
			MODE_INSERT: begin
				if (pos < set_size && set_vals[pos] == v) begin
					res.status = STATUS_DUPLICATE;
				end else if (set_size >= CAPACITY) begin
					res.status = STATUS_FULL;
				end else begin
					for (i = set_size; i > pos; i--)
						set_vals[i] = set_vals[i-1];
					set_vals[pos] = v;
					set_size++;
				end
			end
			MODE_REMOVE: begin
				if (int'(idx) >= set_size) begin
					res.status = STATUS_BAD_INDEX;
				end else begin
					for (i = int'(idx); i < set_size - 1; i++)
						set_vals[i] = set_vals[i+1];
					set_size--;
				end
			end
			MODE_CONTAINS: begin
				res.found = (pos < set_size && set_vals[pos] == v);
			end
			default: begin
				if (int'(idx) >= set_size) begin
					res.read_value = MOST_NEG;
					res.status     = STATUS_BAD_INDEX;
				end else begin
					res.read_value = set_vals[idx];
				end
			end
		endcase
		res.count = set_size[COUNT_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			set_size     = 0;
			peak_size    = 0;
			mismatches   = 0;
			full_rejects = 0;
			bad_indexes  = 0;
		end else begin
			if (item.valid && item.ready) begin
				apply_set_op(mode_t'(item.mode), item.value, item.index, want);
				expected_results.push_back(want);
				if (set_size > peak_size)
					peak_size = set_size;
				if (want.status == STATUS_FULL)
					full_rejects++;
				if (want.status == STATUS_BAD_INDEX)
					bad_indexes++;
			end
			if (result.valid && result.ready) begin
				got = '{count: result.count, found: result.found,
					read_value: result.read_value, status: status_t'(result.status)};
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat: count %0d found %0d value %0d status %0d",
						$time, got.count, got.found, got.read_value, got.status);
				end else begin
					want = expected_results.pop_front();
					if (got.count != want.count || got.found != want.found ||
						got.read_value != want.read_value || got.status != want.status) begin
						mismatches++;
						$display("%0t: mismatch: expected count %0d found %0d value %0d status %0d",
							$time, want.count, want.found, want.read_value, want.status);
						$display("%0t:             actual count %0d found %0d value %0d status %0d",
							$time, got.count, got.found, got.read_value, got.status);
					end
				end
			end
		end
	end

endmodule

>>> dv/sorted_unique_set_engine_tb.sv
`timescale 1ns / 1ps
// Top of the sorted unique set engine testbench: clock, reset, item stimulus and
// result back-pressure; the verdict comes from the failure count of the checker and an idle timeout.
// Depends on sus_pkg, both channel interfaces, the engine and sorted_unique_set_checker.
module sorted_unique_set_engine_tb;
	import sus_pkg::*;

	localparam int HOLD_CYCLES  = 150;
	localparam int IDLE_LIMIT   = 2000;
	localparam int PHASE_ITEMS  = 120;
	localparam int RANDOM_ITEMS = 950;
	localparam int DRAIN_CYCLES = 8;

	localparam logic signed [VALUE_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

	typedef enum {LOAD_GROW, LOAD_MIXED, LOAD_SHRINK} load_t;

	logic clk;
	logic arst_n;
	logic hold_off_req;
	logic hold_off_done;
	int   mismatches;
	int   pending;
	int   set_size;
	int   peak_size;
	int   full_rejects;
	int   bad_indexes;
	int   burst_left;
	int   idle_cycles;
	int   rx_cycle;
	int   sent [4];
	load_t plan [8] = '{LOAD_GROW, LOAD_MIXED, LOAD_GROW, LOAD_SHRINK,
		LOAD_GROW, LOAD_GROW, LOAD_SHRINK, LOAD_MIXED};

	sus_item_if   item_ch ();
	sus_result_if result_ch ();

	sorted_unique_set_engine uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	sorted_unique_set_checker set_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item_ch),
		.result       (result_ch),
		.mismatches   (mismatches),
		.pending      (pending),
		.set_size     (set_size),
		.peak_size    (peak_size),
		.full_rejects (full_rejects),
		.bad_indexes  (bad_indexes)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [VALUE_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			case ($urandom_range(0, 3))
				0: return MOST_NEG;
				1: return MOST_POS;
				2: return MOST_NEG + 1;
				default: return -1;
			endcase
		end
		if (roll < 5)
			return $urandom_range(0, 40) - 20;
		return $urandom;
	endfunction

	// Call at a falling edge; returns after the beat, plus a gap when the burst ends.
	task automatic drive_beat(input mode_t op, input logic signed [VALUE_W-1:0] v,
		input logic [INDEX_W-1:0] idx);
		item_ch.valid <= 1'b1;
		item_ch.mode  <= op;
		item_ch.value <= v;
		item_ch.index <= idx;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		sent[op]++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) :
				$urandom_range(0, 12);
		end
	endtask

	task automatic send_item(input mode_t op, input logic signed [VALUE_W-1:0] v,
		input logic [INDEX_W-1:0] idx);
		@(negedge clk);
		drive_beat(op, v, idx);
	endtask

	task automatic send_random(input load_t load);
		int roll;
		mode_t op;
		logic [INDEX_W-1:0] idx;
		@(negedge clk);
		roll = $urandom_range(0, 99);
		case (load)
			LOAD_GROW:
				op = roll < 80 ? MODE_INSERT : roll < 88 ? MODE_REMOVE :
					roll < 94 ? MODE_CONTAINS : MODE_READ;
			LOAD_SHRINK:
				op = roll < 15 ? MODE_INSERT : roll < 70 ? MODE_REMOVE :
					roll < 85 ? MODE_CONTAINS : MODE_READ;
			default:
				op = roll < 30 ? MODE_INSERT : roll < 55 ? MODE_REMOVE :
					roll < 80 ? MODE_CONTAINS : MODE_READ;
		endcase
		if (set_size > 0 && $urandom_range(0, 4) != 0)
			idx = INDEX_W'($urandom_range(0, set_size - 1));
		else
			idx = INDEX_W'($urandom_range(0, 63));
		drive_beat(op, pick_value(), idx);
	endtask

	// Hold the input until every expected result has come back.
	task automatic drain_results();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		hold_off_req  = 1'b0;
		burst_left    = 0;
		item_ch.valid = 1'b0;
		item_ch.mode  = MODE_INSERT;
		item_ch.value = '0;
		item_ch.index = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		send_item(MODE_READ, $urandom, 0);
		send_item(MODE_REMOVE, $urandom, 0);
		send_item(MODE_CONTAINS, MOST_NEG, 0);
		send_item(MODE_INSERT, MOST_POS, 63);
		send_item(MODE_INSERT, MOST_NEG, 0);
		send_item(MODE_INSERT, 0, 0);
		send_item(MODE_INSERT, -1, 0);
		send_item(MODE_INSERT, 1, 0);
		send_item(MODE_INSERT, MOST_POS, 0);
		send_item(MODE_CONTAINS, MOST_POS, 0);
		send_item(MODE_CONTAINS, MOST_NEG, 0);
		send_item(MODE_CONTAINS, 2, 0);
		send_item(MODE_READ, $urandom, 0);
		send_item(MODE_READ, $urandom, 4);
		send_item(MODE_READ, $urandom, 5);
		send_item(MODE_READ, $urandom, 63);
		send_item(MODE_REMOVE, $urandom, 0);
		send_item(MODE_REMOVE, $urandom, 3);
		send_item(MODE_REMOVE, $urandom, 63);
		send_item(MODE_READ, $urandom, 0);
		send_item(MODE_CONTAINS, MOST_POS, 0);
		drain_results();

		hold_off_req <= 1'b1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				drain_results();
			send_random(plan[(i / PHASE_ITEMS) % 8]);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d inserts, %0d removes, %0d lookups and %0d reads.",
			sent[MODE_INSERT], sent[MODE_REMOVE], sent[MODE_CONTAINS], sent[MODE_READ]);
		$display("Set peaked at %0d of %0d entries; %0d inserts refused as full, %0d bad indexes.",
			peak_size, CAPACITY_DEFAULT, full_rejects, bad_indexes);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		result_ch.ready = 1'b0;
		hold_off_done   = 1'b0;
		rx_cycle        = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (hold_off_req && !hold_off_done) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_done = 1'b1;
			end else begin
				case ((rx_cycle / 97) % 4)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= ($urandom_range(0, 3) != 0);
					2: result_ch.ready <= ($urandom_range(0, 3) == 0);
					default: result_ch.ready <= rx_cycle[2];
				endcase
			end
		end
	end

	initial idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no beat on either channel for %0d cycles", IDLE_LIMIT);
				$display("FAILURE");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
